>>> sv/kctr_pkg.sv
// Shared types, constants and keyword tables for the keyword count text router.
// Depends on nothing; every other file of the block but kctr_queue imports it.
`timescale 1ns / 1ps
`default_nettype none

package kctr_pkg;

	localparam int NUM_KEYWORDS    = 10;
	localparam int WIN_DEPTH       = 8;
	localparam int MATCH_SPAN      = WIN_DEPTH + 1;
	localparam int NUM_CLASSES     = 4;
	localparam int WEIGHT_BITS     = 4;
	localparam int WEIGHT_VEC_BITS = NUM_KEYWORDS * WEIGHT_BITS;
	localparam int CONF_BITS       = 7;
	localparam int CFG_INDEX_BITS  = 3;
	localparam int CFG_DATA_BITS   = WEIGHT_VEC_BITS;
	localparam int SCORE_BITS      = 22;
	localparam int ROUTE_BITS      = 3;
	localparam int LENGTH_OUT_BITS = 16;
	localparam int QUEUE_DEPTH     = 2;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MATERIAL   = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SOIL       = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_WATER      = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MULTI      = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CONFIDENCE = 3'd4;

	// Class positions in weight and score vectors.
	localparam int CLASS_MATERIAL = 0;
	localparam int CLASS_SOIL     = 1;
	localparam int CLASS_WATER    = 2;
	localparam int CLASS_MULTI    = 3;

	// Route codes.
	localparam logic [ROUTE_BITS-1:0] ROUTE_MATERIAL = 3'd0;
	localparam logic [ROUTE_BITS-1:0] ROUTE_SOIL     = 3'd1;
	localparam logic [ROUTE_BITS-1:0] ROUTE_WATER    = 3'd2;
	localparam logic [ROUTE_BITS-1:0] ROUTE_MULTI    = 3'd3;
	localparam logic [ROUTE_BITS-1:0] ROUTE_UNKNOWN  = 3'd4;

	localparam logic [SCORE_BITS-1:0]      SCORE_MAX      = '1;
	localparam logic [LENGTH_OUT_BITS-1:0] LENGTH_OUT_MAX = '1;

	localparam logic [WEIGHT_VEC_BITS-1:0] MATERIAL_WEIGHTS_RST = 40'd8592293898;
	localparam logic [WEIGHT_VEC_BITS-1:0] SOIL_WEIGHTS_RST     = 40'd206242341024;
	localparam logic [WEIGHT_VEC_BITS-1:0] WATER_WEIGHTS_RST    = 40'd18522049024;
	localparam logic [WEIGHT_VEC_BITS-1:0] MULTI_WEIGHTS_RST    = 40'd219046756352;
	localparam logic [CONF_BITS-1:0]       CONF_RST             = 7'd5;

	localparam logic [7:0] UPPER_A  = 8'h41;
	localparam logic [7:0] UPPER_Z  = 8'h5A;
	localparam logic [7:0] CASE_BIT = 8'h20;

	// Keyword text, right aligned: the final character sits in byte 0.
	localparam logic [8*MATCH_SPAN-1:0] KW_TEXT [NUM_KEYWORDS] = '{
		"material", "soil", "water", "compost", "recycle",
		"carbon", "erosion", "aquifer", "pollution", "habitat"
	};
	localparam int KW_LEN [NUM_KEYWORDS] = '{8, 4, 5, 7, 7, 6, 7, 7, 9, 7};

	typedef logic [NUM_CLASSES-1:0][WEIGHT_VEC_BITS-1:0] class_weights_t;
	typedef logic [NUM_CLASSES-1:0][SCORE_BITS-1:0]      scores_t;

	typedef struct packed {
		class_weights_t        weights;
		logic [CONF_BITS-1:0]  conf;
	} route_cfg_t;

	function automatic logic [7:0] fold_case(input logic [7:0] b);
		logic upper;
		upper = (b >= UPPER_A) && (b <= UPPER_Z);
		return upper ? (b | CASE_BIT) : b;
	endfunction

endpackage

`default_nettype wire

>>> sv/kctr_front.sv
// Front end: takes prompt bytes, keeps the match window and the saturating counters.
// Depends on kctr_pkg; hands a snapshot of each finished prompt to the queue.
`timescale 1ns / 1ps
`default_nettype none

module kctr_front import kctr_pkg::*; #(
	parameter int MAX_LENGTH_BITS = 16,
	parameter int COUNT_BITS      = 14
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   push,
	input  logic [7:0]                             text_byte,
	input  logic                                   has_byte,
	input  logic                                   last,
	input  logic                                   q_full,
	output logic                                   full,
	output logic                                   snap_push,
	output logic [NUM_KEYWORDS-1:0][COUNT_BITS-1:0] snap_counts,
	output logic [MAX_LENGTH_BITS-1:0]             snap_length
);

	logic [7:0]                              win_q [WIN_DEPTH];
	logic [NUM_KEYWORDS-1:0][COUNT_BITS-1:0] cnt_q;
	logic [NUM_KEYWORDS-1:0][COUNT_BITS-1:0] cnt_nx;
	logic [MAX_LENGTH_BITS-1:0]              len_q;
	logic [MAX_LENGTH_BITS-1:0]              len_nx;
	logic [7:0]                              cur;
	logic [7:0]                              hist [MATCH_SPAN];
	logic [NUM_KEYWORDS-1:0]                 hit;
	logic                                    accept;

	assign full   = q_full;
	assign accept = push && !q_full;
	assign cur    = fold_case(text_byte);

	always_comb begin
		for (int i = 0; i < WIN_DEPTH; i++) begin
			hist[i] = win_q[i];
		end
		hist[WIN_DEPTH] = cur;
	end

	// Each keyword is compared against the tail of the window ending at the new byte.
	always_comb begin
		for (int k = 0; k < NUM_KEYWORDS; k++) begin
			hit[k] = 1'b1;
			for (int j = 0; j < MATCH_SPAN; j++) begin
				if (j < KW_LEN[k] && hist[WIN_DEPTH-j] != KW_TEXT[k][8*j +: 8]) begin
					hit[k] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NUM_KEYWORDS; k++) begin
			cnt_nx[k] = cnt_q[k];
			if (has_byte && hit[k] && cnt_q[k] != '1) begin
				cnt_nx[k] = cnt_q[k] + COUNT_BITS'(1);
			end
		end
		len_nx = len_q;
		if (has_byte && len_q != '1) begin
			len_nx = len_q + MAX_LENGTH_BITS'(1);
		end
	end

	assign snap_push   = accept && last;
	assign snap_counts = cnt_nx;
	assign snap_length = len_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WIN_DEPTH; i++) begin
				win_q[i] <= '0;
			end
			cnt_q <= '0;
			len_q <= '0;
		end else if (accept) begin
			if (last) begin
				for (int i = 0; i < WIN_DEPTH; i++) begin
					win_q[i] <= '0;
				end
				cnt_q <= '0;
				len_q <= '0;
			end else if (has_byte) begin
				for (int i = 0; i < WIN_DEPTH - 1; i++) begin
					win_q[i] <= win_q[i+1];
				end
				win_q[WIN_DEPTH-1] <= cur;
				cnt_q <= cnt_nx;
				len_q <= len_nx;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/kctr_queue.sv
// Short first-in first-out queue that decouples the front end from the scoring pipeline.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none

module kctr_queue #(
	parameter int WIDTH = 156,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	output logic [WIDTH-1:0] rd_data,
	output logic             full,
	output logic             empty
);

	localparam int PTR_BITS  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_BITS = $clog2(DEPTH + 1);

	logic [WIDTH-1:0]     mem_q [DEPTH];
	logic [PTR_BITS-1:0]  wr_ptr_q;
	logic [PTR_BITS-1:0]  rd_ptr_q;
	logic [FILL_BITS-1:0] fill_q;
	logic                 do_wr;
	logic                 do_rd;

	function automatic logic [PTR_BITS-1:0] ptr_next(input logic [PTR_BITS-1:0] p);
		return (p == PTR_BITS'(DEPTH - 1)) ? '0 : p + PTR_BITS'(1);
	endfunction

	assign full    = (fill_q == FILL_BITS'(DEPTH));
	assign empty   = (fill_q == '0);
	assign do_wr   = wr_en && !full;
	assign do_rd   = rd_en && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= ptr_next(wr_ptr_q);
			end
			if (do_rd) begin
				rd_ptr_q <= ptr_next(rd_ptr_q);
			end
			if (do_wr && !do_rd) begin
				fill_q <= fill_q + FILL_BITS'(1);
			end else if (do_rd && !do_wr) begin
				fill_q <= fill_q - FILL_BITS'(1);
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/kctr_back.sv
// Back end: weights the keyword counts one keyword per stage, picks the route, holds the result.
// Depends on kctr_pkg; reads prompt snapshots from the queue.
`timescale 1ns / 1ps
`default_nettype none

module kctr_back import kctr_pkg::*; #(
	parameter int MAX_LENGTH_BITS = 16,
	parameter int COUNT_BITS      = 14
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  route_cfg_t                             cfg,
	input  logic                                   q_valid,
	input  logic [NUM_KEYWORDS-1:0][COUNT_BITS-1:0] q_counts,
	input  logic [MAX_LENGTH_BITS-1:0]             q_length,
	output logic                                   q_pop,
	input  logic                                   pop,
	output logic                                   empty,
	output logic [ROUTE_BITS-1:0]                  route,
	output logic [SCORE_BITS-1:0]                  material_score,
	output logic [SCORE_BITS-1:0]                  soil_score,
	output logic [SCORE_BITS-1:0]                  water_score,
	output logic [SCORE_BITS-1:0]                  multi_score,
	output logic [LENGTH_OUT_BITS-1:0]             prompt_length
);

	localparam int NSTG        = NUM_KEYWORDS;
	localparam int PROD_BITS   = COUNT_BITS + WEIGHT_BITS;
	localparam int SUM_BITS    = ((PROD_BITS > SCORE_BITS) ? PROD_BITS : SCORE_BITS) + 1;
	localparam int LEN1_BITS   = MAX_LENGTH_BITS + 1;
	localparam int THR_BITS    = CONF_BITS + LEN1_BITS;
	localparam int BEST10_BITS = SCORE_BITS + 4;
	localparam int CMP_BITS    = (THR_BITS > BEST10_BITS) ? THR_BITS : BEST10_BITS;
	localparam int LCMP_BITS   =
		(MAX_LENGTH_BITS > LENGTH_OUT_BITS) ? MAX_LENGTH_BITS : LENGTH_OUT_BITS;

	typedef logic [NUM_KEYWORDS-1:0][COUNT_BITS-1:0] counts_t;

	logic                         adv;
	counts_t                      cnt_in [NSTG];
	logic [MAX_LENGTH_BITS-1:0]   len_in [NSTG];
	scores_t                      acc_in [NSTG];
	scores_t                      acc_nx [NSTG];

	logic [NSTG-1:0]              vld_s;
	counts_t                      cnt_s  [NSTG-1];
	logic [MAX_LENGTH_BITS-1:0]   len_s  [NSTG];
	scores_t                      acc_s  [NSTG];

	logic [SCORE_BITS-1:0]        best;
	logic [ROUTE_BITS-1:0]        pick;
	logic [LEN1_BITS-1:0]         len_inc;
	logic [LENGTH_OUT_BITS-1:0]   len_sat;

	logic                         vld_sf;
	logic [SCORE_BITS-1:0]        best_sf;
	logic [ROUTE_BITS-1:0]        pick_sf;
	scores_t                      score_sf;
	logic [THR_BITS-1:0]          thr_sf;
	logic [LENGTH_OUT_BITS-1:0]   plen_sf;
	logic [CMP_BITS-1:0]          best10;

	logic                         out_vld_q;
	logic [ROUTE_BITS-1:0]        route_q;
	scores_t                      score_q;
	logic [LENGTH_OUT_BITS-1:0]   plen_q;

	// The whole pipeline moves together; it only holds while a result waits unread.
	assign adv   = !out_vld_q || pop;
	assign q_pop = adv && q_valid;

	// Stage k adds count k times its weight to each class score, saturating as it goes.
	always_comb begin
		logic [PROD_BITS-1:0] prod;
		logic [SUM_BITS-1:0]  sum;
		prod = '0;
		sum  = '0;
		cnt_in[0] = q_counts;
		len_in[0] = q_length;
		acc_in[0] = '0;
		for (int k = 1; k < NSTG; k++) begin
			cnt_in[k] = cnt_s[k-1];
			len_in[k] = len_s[k-1];
			acc_in[k] = acc_s[k-1];
		end
		for (int k = 0; k < NSTG; k++) begin
			for (int c = 0; c < NUM_CLASSES; c++) begin
				prod = PROD_BITS'(cnt_in[k][k])
					* PROD_BITS'(cfg.weights[c][WEIGHT_BITS*k +: WEIGHT_BITS]);
				sum  = SUM_BITS'(acc_in[k][c]) + SUM_BITS'(prod);
				acc_nx[k][c] = (sum > SUM_BITS'(SCORE_MAX)) ? SCORE_MAX
					: sum[SCORE_BITS-1:0];
			end
		end
	end

	// Largest score, lowest class first on ties.
	always_comb begin
		best = acc_s[NSTG-1][CLASS_MATERIAL];
		pick = ROUTE_MATERIAL;
		for (int c = 1; c < NUM_CLASSES; c++) begin
			if (acc_s[NSTG-1][c] > best) begin
				best = acc_s[NSTG-1][c];
				pick = ROUTE_BITS'(c);
			end
		end
	end

	assign len_inc = LEN1_BITS'(len_s[NSTG-1]) + LEN1_BITS'(1);
	assign len_sat = (LCMP_BITS'(len_s[NSTG-1]) > LCMP_BITS'(LENGTH_OUT_MAX))
		? LENGTH_OUT_MAX : LENGTH_OUT_BITS'(len_s[NSTG-1]);
	assign best10  = (CMP_BITS'(best_sf) << 3) + (CMP_BITS'(best_sf) << 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s     <= '0;
			vld_sf    <= 1'b0;
			out_vld_q <= 1'b0;
		end else if (adv) begin
			vld_s     <= {vld_s[NSTG-2:0], q_valid};
			vld_sf    <= vld_s[NSTG-1];
			out_vld_q <= vld_sf;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int k = 0; k < NSTG - 1; k++) begin
				cnt_s[k] <= cnt_in[k];
			end
			for (int k = 0; k < NSTG; k++) begin
				len_s[k] <= len_in[k];
				acc_s[k] <= acc_nx[k];
			end
			best_sf  <= best;
			pick_sf  <= pick;
			score_sf <= acc_s[NSTG-1];
			thr_sf   <= THR_BITS'(cfg.conf) * THR_BITS'(len_inc);
			plen_sf  <= len_sat;
			route_q  <= (best10 < CMP_BITS'(thr_sf)) ? ROUTE_UNKNOWN : pick_sf;
			score_q  <= score_sf;
			plen_q   <= plen_sf;
		end
	end

	assign empty          = !out_vld_q;
	assign route          = route_q;
	assign material_score = score_q[CLASS_MATERIAL];
	assign soil_score     = score_q[CLASS_SOIL];
	assign water_score    = score_q[CLASS_WATER];
	assign multi_score    = score_q[CLASS_MULTI];
	assign prompt_length  = plen_q;

endmodule

`default_nettype wire

>>> sv/keyword_count_text_router.sv
// Top level of the keyword count text router: configuration registers and the three parts.
// Depends on kctr_pkg, kctr_front, kctr_queue and kctr_back.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// The input channel looks like the write side of a queue: a beat carries one prompt byte
// (text_byte, has_byte, last) and is taken on a clock edge with push high and full low.
// Bytes are case folded and counted, and ten keywords are matched over the newest nine
// characters. An input beat with has_byte low adds nothing; with last high it still ends
// the prompt. The front end accepts one beat every cycle while full is low.
// The result channel looks like the read side of a queue: while empty is low, the oldest
// result beat (route, four class scores and prompt_length) is on the ports, and it is
// taken on a clock edge with pop high. One result beat follows each beat marked last; its
// snapshot passes the queue, ten keyword-weighting stages, a route pick stage and the
// output register. Results leave at up to one per cycle.
// When the receiver stalls, the scoring pipeline holds; a two-entry snapshot queue keeps
// the front end running until two finished prompts wait in it, after which full rises.
// Configuration is a plain write port (cfg_write, cfg_index, cfg_data); indexes 0 to 3
// load the class weight vectors and index 4 the confidence threshold in tenths.
// Unused indexes are ignored. Write the registers only while no prompt is in flight.
// Reset clears the prompt state, empties the queue and the pipeline, and loads the
// default weights and a threshold of five tenths.

module keyword_count_text_router import kctr_pkg::*; #(
	parameter int MAX_LENGTH_BITS = 16,
	parameter int COUNT_BITS      = 14
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_write,
	input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                       push,
	output logic                       full,
	input  logic [7:0]                 text_byte,
	input  logic                       has_byte,
	input  logic                       last,
	output logic                       empty,
	input  logic                       pop,
	output logic [ROUTE_BITS-1:0]      route,
	output logic [SCORE_BITS-1:0]      material_score,
	output logic [SCORE_BITS-1:0]      soil_score,
	output logic [SCORE_BITS-1:0]      water_score,
	output logic [SCORE_BITS-1:0]      multi_score,
	output logic [LENGTH_OUT_BITS-1:0] prompt_length
);

	localparam int COUNTS_BITS = NUM_KEYWORDS * COUNT_BITS;
	localparam int SNAP_BITS   = COUNTS_BITS + MAX_LENGTH_BITS;

	route_cfg_t                              cfg_q;
	logic                                    snap_push;
	logic [NUM_KEYWORDS-1:0][COUNT_BITS-1:0] snap_counts;
	logic [MAX_LENGTH_BITS-1:0]              snap_length;
	logic [SNAP_BITS-1:0]                    q_rd_data;
	logic                                    q_full;
	logic                                    q_empty;
	logic                                    q_pop;

	// Configuration registers. They must only be written while the block is idle, so that the
	// scoring pipeline can read them directly; the block itself does not enforce this.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.weights[CLASS_MATERIAL] <= MATERIAL_WEIGHTS_RST;
			cfg_q.weights[CLASS_SOIL]     <= SOIL_WEIGHTS_RST;
			cfg_q.weights[CLASS_WATER]    <= WATER_WEIGHTS_RST;
			cfg_q.weights[CLASS_MULTI]    <= MULTI_WEIGHTS_RST;
			cfg_q.conf                    <= CONF_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_MATERIAL:   cfg_q.weights[CLASS_MATERIAL] <= cfg_data;
				CFG_SOIL:       cfg_q.weights[CLASS_SOIL]     <= cfg_data;
				CFG_WATER:      cfg_q.weights[CLASS_WATER]    <= cfg_data;
				CFG_MULTI:      cfg_q.weights[CLASS_MULTI]    <= cfg_data;
				CFG_CONFIDENCE: cfg_q.conf <= cfg_data[CONF_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	// Front end: window, keyword matching and saturating counters. On the last beat of a
	// prompt it pushes the final counts and length and starts the next prompt clean.
	kctr_front #(
		.MAX_LENGTH_BITS(MAX_LENGTH_BITS),
		.COUNT_BITS     (COUNT_BITS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.text_byte  (text_byte),
		.has_byte   (has_byte),
		.last       (last),
		.q_full     (q_full),
		.full       (full),
		.snap_push  (snap_push),
		.snap_counts(snap_counts),
		.snap_length(snap_length)
	);

	kctr_queue #(
		.WIDTH(SNAP_BITS),
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (snap_push),
		.wr_data({snap_counts, snap_length}),
		.rd_en  (q_pop),
		.rd_data(q_rd_data),
		.full   (q_full),
		.empty  (q_empty)
	);

	// Back end: weighted sums, route choice against the threshold, output register.
	kctr_back #(
		.MAX_LENGTH_BITS(MAX_LENGTH_BITS),
		.COUNT_BITS     (COUNT_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg_q),
		.q_valid       (!q_empty),
		.q_counts      (q_rd_data[SNAP_BITS-1:MAX_LENGTH_BITS]),
		.q_length      (q_rd_data[MAX_LENGTH_BITS-1:0]),
		.q_pop         (q_pop),
		.pop           (pop),
		.empty         (empty),
		.route         (route),
		.material_score(material_score),
		.soil_score    (soil_score),
		.water_score   (water_score),
		.multi_score   (multi_score),
		.prompt_length (prompt_length)
	);

endmodule

`default_nettype wire

>>> sv/kctr_chk.sv
// Port-level checker for the keyword count text router, bound to its top level.
// Depends on kctr_pkg for route codes and field widths.
`timescale 1ns / 1ps
`default_nettype none

module kctr_chk import kctr_pkg::*; (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       pop,
	input logic                       empty,
	input logic [ROUTE_BITS-1:0]      route,
	input logic [SCORE_BITS-1:0]      material_score,
	input logic [SCORE_BITS-1:0]      soil_score,
	input logic [SCORE_BITS-1:0]      water_score,
	input logic [SCORE_BITS-1:0]      multi_score,
	input logic [LENGTH_OUT_BITS-1:0] prompt_length
);

	localparam logic [LENGTH_OUT_BITS-1:0] SHORTEST_KEYWORD = 16'd4;

	// Nothing is offered right after reset is released.
	a_empty_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> empty)
		else $error("result offered right after reset");

	// A result that is not taken stays on the ports unchanged.
	a_hold_result: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(route) && $stable(material_score)
			&& $stable(soil_score) && $stable(water_score) && $stable(multi_score)
			&& $stable(prompt_length))
		else $error("waiting result changed or vanished");

	// A known route names the best class, the lowest class winning ties.
	a_route_is_best: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && route != ROUTE_UNKNOWN |->
			(route == ROUTE_MATERIAL && material_score >= soil_score
				&& material_score >= water_score && material_score >= multi_score)
			|| (route == ROUTE_SOIL && soil_score > material_score
				&& soil_score >= water_score && soil_score >= multi_score)
			|| (route == ROUTE_WATER && water_score > material_score
				&& water_score > soil_score && water_score >= multi_score)
			|| (route == ROUTE_MULTI && multi_score > material_score
				&& multi_score > soil_score && multi_score > water_score))
		else $error("route does not match the best score");

	// A prompt shorter than the shortest keyword cannot score.
	a_short_prompt: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && prompt_length < SHORTEST_KEYWORD |->
			material_score == '0 && soil_score == '0 && water_score == '0
			&& multi_score == '0)
		else $error("nonzero score for a prompt too short to hold a keyword");

endmodule

bind keyword_count_text_router kctr_chk u_kctr_chk (.*);

`default_nettype wire
